// File: rtl/core/fef_pkg.sv
`default_nettype none

package fef_pkg;

  // frame geometry
  localparam int WIDTH  = 256;
  localparam int HEIGHT = 128;
  localparam int CELLS  = WIDTH * HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  // field widths
  localparam int REQ_W  = 2;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int HEAT_W = 8;
  localparam int RGB_W  = 3 * HEAT_W;

  // sum of four heat values
  localparam int SUM_W = HEAT_W + 2;

  // sum * 100 / 403 as a multiply by a rounded-up scaled reciprocal; the excess
  // stays below 1/403 for every sum up to 1020, so no correction step is needed
  localparam int DIV_MUL   = 260193;
  localparam int DIV_SHIFT = 20;
  localparam int PROD_W    = SUM_W + 18;
  localparam int MAX_Q     = 253;

  // neighbor read sequence: three reads from the row below, one two rows down
  localparam int NB_READS = 4;
  localparam int STEP_W   = $clog2(NB_READS + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_SEED   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_LOOK,
    S_CAP,
    S_RD,
    S_DIV,
    S_WB,
    S_OUT
  } fef_state_t;

  typedef logic [RGB_W-1:0] pal_t [256];

  // black-red-orange-yellow-white ramp, red in the top byte
  function automatic pal_t build_palette();
    pal_t tab;
    int r;
    int g;
    int b;
    int k;
    for (int h = 0; h < 256; h++) begin
      if (h <= 32) begin
        r = 4 * h;
        g = 0;
        b = 0;
      end else if (h <= 64) begin
        k = h - 32;
        r = 128 + 2 * k;
        g = 4 * k;
        b = 0;
      end else if (h <= 95) begin
        k = h - 64;
        r = 192;
        g = 128 + 2 * k;
        b = 0;
      end else begin
        k = h - 96;
        r = 192 + (63 * k) / 159;
        g = r;
        b = (255 * k) / 159;
      end
      tab[h] = {8'(r), 8'(g), 8'(b)};
    end
    return tab;
  endfunction

  localparam pal_t PALETTE = build_palette();

  // linear frame address of pixel (x, y)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                  input logic [ROW_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(WIDTH)) + ADDR_W'(x);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fef_in_if.sv
`default_nettype none

interface fef_in_if import fef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [HEAT_W-1:0] heat_in;

  modport source (output valid, req_type, col, row, heat_in, input ready);
  modport sink   (input valid, req_type, col, row, heat_in, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fef_out_if.sv
`default_nettype none

interface fef_out_if import fef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_out;
  logic [HEAT_W-1:0] red;
  logic [HEAT_W-1:0] green;
  logic [HEAT_W-1:0] blue;

  modport source (output valid, heat_out, red, green, blue, input ready);
  modport sink   (input valid, heat_out, red, green, blue, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fef_ram.sv
`default_nettype none

module fef_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/fef_heat_div.sv
`default_nettype none

module fef_heat_div import fef_pkg::*; (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [SUM_W-1:0]  sum_i,
  output logic      [HEAT_W-1:0] quot_o
);

  logic [PROD_W-1:0] prod_r;

  // sum scaled by 100/403 in fixed point
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(PROD_W'(sum_i) * PROD_W'(DIV_MUL));
    end
  end

  assign quot_o = prod_r[DIV_SHIFT +: HEAT_W];

endmodule

`default_nettype wire

// File: rtl/core/fire_effect_frame_engine.sv
`default_nettype none

// Fire effect frame engine. Keeps a WIDTH x HEIGHT frame of 8-bit heat values
// in one single-port memory and serves one request at a time: seed writes
// heat_in into the bottom row at col, update recomputes pixel (col,row) as
// floor(100*sum/403) of the three pixels below and the one two rows down
// (columns and rows wrap; the bottom row is left as is), read changes
// nothing. Each request returns one word with the pixel's heat and its
// palette color. After reset the block zeroes all CELLS (32768) words of the
// frame memory before it takes the first request. An out-of-range request
// goes straight to the result, a seed writes the memory, and a read or a
// bottom-row update looks up and captures the pixel; any other update makes
// its four neighbor reads through the memory port, one per cycle, followed by
// the reciprocal multiply and the write-back. The result sits in an output
// register, so a new request is taken while the previous word waits.
module fire_effect_frame_engine import fef_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fef_in_if.sink     in_ch,
  fef_out_if.source  out_ch
);

  fef_state_t        state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [HEAT_W-1:0] hin_r, hin_nxt;
  logic [HEAT_W-1:0] heat_r, heat_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HEAT_W-1:0] out_heat_r, out_heat_nxt;
  logic [RGB_W-1:0]  out_rgb_r, out_rgb_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [HEAT_W-1:0] ram_wdata;
  logic [HEAT_W-1:0] ram_rdata;
  logic              div_load;
  logic [HEAT_W-1:0] div_q;

  logic              accept;
  logic [ROW_W-1:0]  in_y;
  logic              in_ok;
  logic [COL_W-1:0]  xl, xr;
  logic [ROW_W-1:0]  y1, y2;
  logic [ADDR_W-1:0] nb_addr;

  // frame memory and divide unit
  fef_ram #(
    .DATA_W (HEAT_W),
    .DEPTH  (CELLS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fef_heat_div u_div (
    .clk    (clk),
    .load   (div_load),
    .sum_i  (sum_r),
    .quot_o (div_q)
  );

  // request decode
  assign accept = in_ch.valid && in_ch.ready;
  assign in_y   = (in_ch.req_type == REQ_SEED) ? ROW_W'(HEIGHT - 1) : in_ch.row;
  assign in_ok  = (32'(in_ch.col) < 32'(WIDTH)) && (32'(in_y) < 32'(HEIGHT));

  // neighbor coordinates with wrap
  assign xl = (col_r == '0) ? COL_W'(WIDTH - 1) : COL_W'(col_r - 1'b1);
  assign xr = (32'(col_r) + 32'd1 == 32'(WIDTH)) ? '0 : COL_W'(col_r + 1'b1);
  assign y1 = ROW_W'(row_r + 1'b1);
  assign y2 = (32'(row_r) + 32'd2 >= 32'(HEIGHT)) ?
              ROW_W'(32'(row_r) + 32'd2 - 32'(HEIGHT)) : ROW_W'(row_r + 2'd2);

  always_comb begin
    case (step_r)
      STEP_W'(0): nb_addr = cell_addr(xl, y1);
      STEP_W'(1): nb_addr = cell_addr(col_r, y1);
      STEP_W'(2): nb_addr = cell_addr(xr, y1);
      default:    nb_addr = cell_addr(col_r, y2);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    hin_nxt       = hin_r;
    heat_nxt      = heat_r;
    sum_nxt       = sum_r;
    step_nxt      = step_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_heat_nxt  = out_heat_r;
    out_rgb_nxt   = out_rgb_r;
    ram_we        = 1'b0;
    ram_addr      = cell_addr(col_r, row_r);
    ram_wdata     = hin_r;
    div_load      = 1'b0;
    in_ch.ready   = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = ADDR_W'(clr_r + 1'b1);
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // ready is high here, so a valid word is taken this cycle
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          req_nxt = in_ch.req_type;
          col_nxt = in_ch.col;
          row_nxt = in_y;
          hin_nxt = in_ch.heat_in;
          if (!in_ok) begin
            heat_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            case (in_ch.req_type)
              REQ_SEED: begin
                state_nxt = S_SEED;
              end
              REQ_UPDATE: begin
                if (32'(in_y) < 32'(HEIGHT - 1)) begin
                  step_nxt  = '0;
                  sum_nxt   = '0;
                  state_nxt = S_RD;
                end else begin
                  state_nxt = S_LOOK;
                end
              end
              default: begin
                state_nxt = S_LOOK;
              end
            endcase
          end
        end
      end
      S_SEED: begin
        ram_we    = 1'b1;
        heat_nxt  = hin_r;
        state_nxt = S_OUT;
      end
      S_LOOK: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        heat_nxt  = ram_rdata;
        state_nxt = S_OUT;
      end
      S_RD: begin
        // one read issued per step, data of the previous read accumulated
        ram_addr = nb_addr;
        if (step_r != '0) begin
          sum_nxt = SUM_W'(sum_r + SUM_W'(ram_rdata));
        end
        step_nxt = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(NB_READS)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_load  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_wdata = div_q;
        heat_nxt  = div_q;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_heat_nxt  = heat_r;
          out_rgb_nxt   = PALETTE[heat_r];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    hin_r      <= hin_nxt;
    heat_r     <= heat_nxt;
    sum_r      <= sum_nxt;
    out_heat_r <= out_heat_nxt;
    out_rgb_r  <= out_rgb_nxt;
  end

  // result word
  assign out_ch.valid    = out_valid_r;
  assign out_ch.heat_out = out_heat_r;
  assign out_ch.red      = out_rgb_r[2*HEAT_W +: HEAT_W];
  assign out_ch.green    = out_rgb_r[HEAT_W +: HEAT_W];
  assign out_ch.blue     = out_rgb_r[0 +: HEAT_W];

  // the request code is kept for debug visibility of the word in flight
  logic req_seen;
  assign req_seen = (req_r == REQ_SEED) || (req_r == REQ_UPDATE) || (req_r == REQ_READ);

  // checks
  a_color_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({out_ch.red, out_ch.green, out_ch.blue} == PALETTE[out_ch.heat_out]))
    else $error("result color does not match its heat");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_SEED || state_r == S_WB))
    else $error("frame write outside clear, seed or write-back");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("request taken while previous one in progress");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (32'(div_q) <= 32'(MAX_Q)))
    else $error("scaled heat above the largest reachable value");

  a_update_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (req_seen && req_r == REQ_UPDATE))
    else $error("neighbor reads without an update request");

endmodule

`default_nettype wire
